// ----- design/u8d_pkg.sv -----
// u8d_pkg: types and constants shared by the UTF-8 byte decoder.
// No dependencies; compiled before the interfaces and modules.
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;

  localparam logic [CpW-1:0] Replacement = 21'd65533;
  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLo      = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi      = 21'h00DFFF;
  localparam logic [CpW-1:0] NoncharA    = 21'h00FFFE;
  localparam logic [CpW-1:0] NoncharB    = 21'h00FFFF;
  localparam logic [CpW-1:0] MinTwo      = 21'd128;
  localparam logic [CpW-1:0] MinThree    = 21'd2048;
  localparam logic [CpW-1:0] MinFour     = 21'd65536;

  localparam logic [CountW-1:0] LenTwo   = 3'd2;
  localparam logic [CountW-1:0] LenThree = 3'd3;
  localparam logic [CountW-1:0] LenFour  = 3'd4;
  localparam logic [CountW-1:0] CntIdle  = 3'd0;
  localparam logic [CountW-1:0] CntLast  = 3'd1;

  typedef struct packed {
    logic [CpW-1:0]    acc;
    logic [CountW-1:0] rem;
    logic [CountW-1:0] exp_len;
  } dec_state_t;

  typedef struct packed {
    logic              char_valid;
    logic [CpW-1:0]    code_point;
    logic              bad_sequence;
    logic [CountW-1:0] bytes_awaited;
  } dec_result_t;

endpackage

// ----- design/u8d_if.sv -----
// u8d_if: valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on u8d_pkg for field widths.
interface u8d_in_if;
  logic                         valid;
  logic                         ready;
  logic [u8d_pkg::ByteW-1:0]    byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_out_if;
  logic                         valid;
  logic                         ready;
  logic                         char_valid;
  logic [u8d_pkg::CpW-1:0]      code_point;
  logic                         bad_sequence;
  logic [u8d_pkg::CountW-1:0]   bytes_awaited;

  modport source (output valid, output char_valid, output code_point,
                  output bad_sequence, output bytes_awaited, input ready);
  modport sink   (input valid, input char_valid, input code_point,
                  input bad_sequence, input bytes_awaited, output ready);
endinterface

// ----- design/utf8_byte_decoder.sv -----
// utf8_byte_decoder: UTF-8 byte stream decoder, one result word per byte word.
// A byte accepted into the input register is decoded once the result side is free; its
// result word is held in the result register until taken. Throughput: one byte per cycle
// unless the result side stalls; the single-pass decode step sits between the two registers.
// Reset (rst_n, synchronous): clears decoder state and both valid flags; no clearing pass.
// Depends on u8d_pkg, u8d_if, u8d_in_stage and u8d_step.
module utf8_byte_decoder (
  input  logic       clk,
  input  logic       rst_n,
  u8d_in_if.sink     in_ch,
  u8d_out_if.source  out_ch
);

  logic                       held_valid;
  logic [u8d_pkg::ByteW-1:0]  held_byte;
  logic                       advance;

  u8d_pkg::dec_state_t        st_r;
  u8d_pkg::dec_state_t        st_nxt;
  u8d_pkg::dec_result_t       step_res;
  u8d_pkg::dec_result_t       res_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;

  assign advance = held_valid && (!out_valid_r || out_ch.ready);

  u8d_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  u8d_step u_step (
    .byte_in (held_byte),
    .cur     (st_r),
    .nxt     (st_nxt),
    .res     (step_res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= step_res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.char_valid    = res_r.char_valid;
  assign out_ch.code_point    = res_r.code_point;
  assign out_ch.bad_sequence  = res_r.bad_sequence;
  assign out_ch.bytes_awaited = res_r.bytes_awaited;

`ifndef SYNTHESIS
  a_emit_no_await: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.char_valid) |-> (out_ch.bytes_awaited == u8d_pkg::CntIdle))
    else $error("result word emits a character but reports bytes awaited");

  a_bad_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.bad_sequence) |->
      (out_ch.char_valid && (out_ch.code_point == u8d_pkg::Replacement)))
    else $error("bad sequence without replacement character");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.rem == u8d_pkg::CntIdle) || (st_r.rem == u8d_pkg::LenTwo)
      || (st_r.rem == u8d_pkg::LenThree) || (st_r.rem == u8d_pkg::LenFour))
    else $error("remaining count holds an unreachable value");

  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_ch.valid || out_ch.ready) |-> in_ch.ready)
    else $error("input stalled while result side is free");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(advance) && ($past(st_r.rem) > u8d_pkg::LenTwo) && !out_ch.bad_sequence)
      |-> (st_r.rem == $past(st_r.rem) - u8d_pkg::CntLast))
    else $error("remaining count did not step down by one");
`endif

endmodule

// ----- design/u8d_in_stage.sv -----
// u8d_in_stage: input register of the decoder; holds one byte word until the step takes it.
// Depends on u8d_pkg and u8d_in_if.
module u8d_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  u8d_in_if.sink                    in_ch,
  input  logic                      advance,
  output logic                      held_valid,
  output logic [u8d_pkg::ByteW-1:0] held_byte
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [u8d_pkg::ByteW-1:0] byte_r;
  logic                      take;

  assign in_ch.ready = !valid_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.byte_in;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

// ----- design/u8d_step.sv -----
// u8d_step: one decode step; next decoder state and the result word for one byte.
// Depends on u8d_pkg.
module u8d_step (
  input  logic [u8d_pkg::ByteW-1:0] byte_in,
  input  u8d_pkg::dec_state_t       cur,
  output u8d_pkg::dec_state_t       nxt,
  output u8d_pkg::dec_result_t      res
);

  logic                      is_cont;
  logic                      finish;
  logic                      bad;
  logic [u8d_pkg::CpW-1:0]   value;
  logic [u8d_pkg::CpW-1:0]   shifted;
  logic [u8d_pkg::CountW-1:0] rem_dec;

  assign is_cont = (byte_in[7:6] == 2'b10);
  assign shifted = {cur.acc[u8d_pkg::CpW-7:0], byte_in[5:0]};
  assign rem_dec = cur.rem - u8d_pkg::CntLast;

  always_comb begin
    nxt    = cur;
    res    = '0;
    finish = 1'b0;
    value  = cur.acc;

    if (cur.rem == u8d_pkg::CntIdle) begin
      unique case (byte_in) inside
        8'b0???_????: begin
          res.char_valid = 1'b1;
          res.code_point = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_in};
          nxt.acc        = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_in};
          nxt.rem        = u8d_pkg::CntIdle;
          nxt.exp_len    = u8d_pkg::CntIdle;
        end
        8'b110?_????: begin
          nxt.acc           = {16'd0, byte_in[4:0]};
          nxt.rem           = u8d_pkg::LenTwo;
          nxt.exp_len       = u8d_pkg::LenTwo;
          res.bytes_awaited = u8d_pkg::LenTwo;
        end
        8'b1110_????: begin
          nxt.acc           = {17'd0, byte_in[3:0]};
          nxt.rem           = u8d_pkg::LenThree;
          nxt.exp_len       = u8d_pkg::LenThree;
          res.bytes_awaited = u8d_pkg::LenThree;
        end
        8'b1111_0???: begin
          nxt.acc           = {18'd0, byte_in[2:0]};
          nxt.rem           = u8d_pkg::LenFour;
          nxt.exp_len       = u8d_pkg::LenFour;
          res.bytes_awaited = u8d_pkg::LenFour;
        end
        default: begin
          res.char_valid   = 1'b1;
          res.code_point   = u8d_pkg::Replacement;
          res.bad_sequence = 1'b1;
          nxt.acc          = {{(u8d_pkg::CpW-u8d_pkg::ByteW){1'b0}}, byte_in};
          nxt.rem          = u8d_pkg::CntIdle;
          nxt.exp_len      = u8d_pkg::CntIdle;
        end
      endcase
    end else if (cur.rem > u8d_pkg::CntLast) begin
      if (is_cont) begin
        nxt.acc = shifted;
        nxt.rem = rem_dec;
        if (rem_dec != u8d_pkg::CntLast) begin
          res.bytes_awaited = rem_dec;
        end else begin
          finish = 1'b1;
          value  = shifted;
        end
      end else begin
        res.char_valid   = 1'b1;
        res.code_point   = u8d_pkg::Replacement;
        res.bad_sequence = 1'b1;
        nxt.rem          = u8d_pkg::CntIdle;
      end
    end else begin
      finish = 1'b1;
    end

    bad = (value < u8d_pkg::MinTwo)
       || ((value < u8d_pkg::MinThree) && (cur.exp_len > u8d_pkg::LenTwo))
       || ((value < u8d_pkg::MinFour) && (cur.exp_len > u8d_pkg::LenThree))
       || (value > u8d_pkg::CpMax)
       || ((value >= u8d_pkg::SurrLo) && (value <= u8d_pkg::SurrHi))
       || (value == u8d_pkg::NoncharA)
       || (value == u8d_pkg::NoncharB);

    if (finish) begin
      res.char_valid    = 1'b1;
      res.bad_sequence  = bad;
      res.code_point    = bad ? u8d_pkg::Replacement : value;
      res.bytes_awaited = u8d_pkg::CntIdle;
      nxt.rem           = u8d_pkg::CntIdle;
    end
  end

endmodule
